@@ rtl/twcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcd_pkg: shared types and constants
// Codes, widths and state types for the temporary write-cache disable counter.
// ----------------------------------------------------------------------------
package twcd_pkg;

  localparam int NUM_USERS  = 16;
  localparam int USER_W     = 4;
  localparam int USER_IDX_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int OPT_W      = 2;
  localparam int COUNT_W    = 8;
  localparam int ACTIVE_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [OPT_W-1:0] {
    OPT_ONE = 2'd0,
    OPT_ALL = 2'd1
  } opt_t;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_BAD_OPT = 1'b1
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  typedef struct packed {
    logic                  en;
    logic [USER_IDX_W-1:0] addr;
    logic [COUNT_W-1:0]    data;
  } mem_wr_t;

endpackage

@@ rtl/twcd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcd_in_if / twcd_out_if: item channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface twcd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [twcd_pkg::USER_W-1:0]          user;
  logic [twcd_pkg::OPT_W-1:0]           clear_option;
  logic                                 cache_enabled;
  logic                                 disable_in_progress;
  logic                                 other_disables_active;

  modport source (
    output valid, command, user, clear_option, cache_enabled,
           disable_in_progress, other_disables_active,
    input  ready
  );
  modport sink (
    input  valid, command, user, clear_option, cache_enabled,
           disable_in_progress, other_disables_active,
    output ready
  );
endinterface

interface twcd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 status;
  logic                                 temp_disabled;
  logic                                 request_global_disable;
  logic                                 request_global_enable;
  logic [twcd_pkg::ACTIVE_W-1:0]        active_users;

  modport source (
    output valid, status, temp_disabled, request_global_disable,
           request_global_enable, active_users,
    input  ready
  );
  modport sink (
    input  valid, status, temp_disabled, request_global_disable,
           request_global_enable, active_users,
    output ready
  );
endinterface

@@ rtl/temp_write_cache_disable_refcount_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_write_cache_disable_refcount_top: temporary write-cache disable counter
// Counts temporary write-cache disable requests per user and raises the
// global disable and enable pulses.
// ----------------------------------------------------------------------------
// Usage:
// Request items arrive on the req channel: a set or clear command, the user,
// the clear option and three status bits of the write cache. Every accepted
// item produces exactly one result item on the rsp channel with the status,
// the temporary-disable flag, the two request pulses and the count of users
// that hold requests.
// Each item passes through S_IDLE and S_CALC: the accept cycle in S_IDLE reads
// the user's count from the count memory, and S_CALC modifies it, writes it
// back and loads the result register. The next item can be accepted only once
// the block is back in S_IDLE, so an item is not taken before the last one has
// finished the single read-modify-write of the count memory.
// The result register parts the two sides: a new item is accepted while the
// previous result still waits. If a result is still waiting when the next one
// is ready, the block holds in S_CALC until rsp is taken.
// Reset clears all counts, the active-user count and both flags at once; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module temp_write_cache_disable_refcount_top (
  input  logic        clk,
  input  logic        rst,
  twcd_in_if.sink     req,
  twcd_out_if.source  rsp
);

  twcd_pkg::state_t state, state_next;

  logic                               cmd_q;
  logic [twcd_pkg::USER_W-1:0]        user_q;
  logic [twcd_pkg::OPT_W-1:0]         opt_q;
  logic                               ena_q;
  logic                               dip_q;
  logic                               others_q;

  logic [twcd_pkg::ACTIVE_W-1:0]      users, users_next;
  logic                               flag, flag_next;
  logic                               pend, pend_next;

  logic [twcd_pkg::COUNT_W-1:0]       cnt, cnt_next;
  logic                               in_range;
  logic                               status_c, dis_c, ena_c;
  logic                               accept, load;
  twcd_pkg::mem_wr_t                  wr;

  assign accept = req.valid && req.ready;

  twcd_count_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (twcd_pkg::USER_IDX_W'(req.user)),
    .rd_data (cnt),
    .wr      (wr)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= req.command;
      user_q   <= req.user;
      opt_q    <= req.clear_option;
      ena_q    <= req.cache_enabled;
      dip_q    <= req.disable_in_progress;
      others_q <= req.other_disables_active;
    end
  end

  always_comb begin
    in_range   = 32'(user_q) < twcd_pkg::NUM_USERS;
    cnt_next   = cnt;
    users_next = users;
    flag_next  = flag;
    pend_next  = pend;
    status_c   = twcd_pkg::STATUS_OK;
    dis_c      = 1'b0;
    ena_c      = 1'b0;
    if (in_range) begin
      if (cmd_q == twcd_pkg::CMD_SET) begin
        if (cnt == '0) begin
          users_next = users + 1'b1;
        end
        if (cnt != twcd_pkg::COUNT_MAX) begin
          cnt_next = cnt + 1'b1;
        end
        if (users == '0) begin
          flag_next = 1'b1;
          if (ena_q && !dip_q) begin
            dis_c     = 1'b1;
            pend_next = 1'b1;
          end
        end
      end else if (users != '0 && cnt != '0) begin
        case (opt_q)
          twcd_pkg::OPT_ONE: cnt_next = cnt - 1'b1;
          twcd_pkg::OPT_ALL: cnt_next = '0;
          default:           status_c = twcd_pkg::STATUS_BAD_OPT;
        endcase
        if (status_c == twcd_pkg::STATUS_OK) begin
          if (cnt_next == '0) begin
            users_next = users - 1'b1;
          end
          if (users_next == '0) begin
            flag_next = 1'b0;
            if (!others_q && pend) begin
              pend_next = 1'b0;
              ena_c     = 1'b1;
            end
          end
        end
      end
    end
  end

  assign load    = (state == twcd_pkg::S_CALC) && (!rsp.valid || rsp.ready);
  assign wr.en   = load && in_range && (cnt_next != cnt);
  assign wr.addr = twcd_pkg::USER_IDX_W'(user_q);
  assign wr.data = cnt_next;

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      twcd_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = twcd_pkg::S_CALC;
        end
      end
      twcd_pkg::S_CALC: begin
        if (load) begin
          state_next = twcd_pkg::S_IDLE;
        end
      end
      default: state_next = twcd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twcd_pkg::S_IDLE;
      users     <= '0;
      flag      <= 1'b0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        users     <= users_next;
        flag      <= flag_next;
        pend      <= pend_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status                 <= status_c;
      rsp.temp_disabled          <= flag_next;
      rsp.request_global_disable <= dis_c;
      rsp.request_global_enable  <= ena_c;
      rsp.active_users           <= users_next;
    end
  end

  a_accept_then_calc: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == twcd_pkg::S_CALC)
    else $error("accepted item did not move to the update cycle");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == twcd_pkg::S_CALC && rsp.valid && !rsp.ready) |=> state == twcd_pkg::S_CALC)
    else $error("update cycle left while the result register was full");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.request_global_disable && rsp.request_global_enable))
    else $error("disable and enable pulses in the same result");

  a_bad_opt_no_pulse: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == twcd_pkg::STATUS_BAD_OPT)
      |-> !rsp.request_global_disable && !rsp.request_global_enable)
    else $error("rejected clear produced a pulse");

  a_users_bound: assert property (@(posedge clk) disable iff (rst)
    32'(users) <= twcd_pkg::NUM_USERS)
    else $error("active user count exceeds the number of users");

  a_flag_tracks_users: assert property (@(posedge clk) disable iff (rst)
    flag == (users != '0))
    else $error("temporary-disable flag out of step with the active users");

endmodule

@@ rtl/twcd_count_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcd_count_mem: per-user request count memory
// Synchronous memory with a registered read; entries never written read
// as zero through per-entry valid bits cleared at reset.
// ----------------------------------------------------------------------------
module twcd_count_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic [twcd_pkg::USER_IDX_W-1:0]     rd_addr,
  output logic [twcd_pkg::COUNT_W-1:0]        rd_data,
  input  twcd_pkg::mem_wr_t                   wr
);

  logic [twcd_pkg::COUNT_W-1:0] mem [twcd_pkg::NUM_USERS];
  logic [twcd_pkg::NUM_USERS-1:0] vld;
  logic [twcd_pkg::COUNT_W-1:0] rd_raw;
  logic rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule
